// File: design/tfma_pkg.sv
// tfma_pkg: shared widths, reset values, codes and bundle types for the
// temperature calibration / moving average / classifier block.
// No dependencies; imported by every design module except tfma_check.
package tfma_pkg;

   // field widths
   localparam int ADC_W  = 16;
   localparam int TEMP_W = 19;
   localparam int LVL_IN_W = 16;

   // default ring length
   localparam int WINDOW_LEN_DEF = 20;

   // register reset values
   localparam logic signed [16:0] QUAD_RST       = -17'sd36299;
   localparam logic signed [15:0] LIN_RST        = -16'sd11595;
   localparam logic [15:0]        OFFSET_RST     = 16'd52325;
   localparam logic [15:0]        FEVER_RST      = 16'd9549;
   localparam logic [15:0]        HIGH_FEVER_RST = 16'd9805;

   // register indexes
   localparam logic [2:0] REG_QUAD       = 3'd0;
   localparam logic [2:0] REG_LIN        = 3'd1;
   localparam logic [2:0] REG_OFFSET     = 3'd2;
   localparam logic [2:0] REG_FEVER      = 3'd3;
   localparam logic [2:0] REG_HIGH_FEVER = 3'd4;

   // classification codes
   localparam logic [1:0] BODY_NORMAL     = 2'd0;
   localparam logic [1:0] BODY_FEVER      = 2'd1;
   localparam logic [1:0] BODY_HIGH_FEVER = 2'd2;

   // configuration bundle
   typedef struct packed {
      logic signed [16:0] quad_coef;
      logic signed [15:0] lin_coef;
      logic [15:0]        offset_temp;
      logic [15:0]        fever_level;
      logic [15:0]        high_fever_level;
   } tfma_cfg_type;

   // stage enables from the controller to the datapath
   typedef struct packed {
      logic load_in;
      logic mul1;
      logic mul2;
      logic acc;
      logic upd;
      logic diva;
      logic divb;
      logic load_out;
   } tfma_cmd_type;

endpackage

// File: design/tfma_csr.sv
// tfma_csr: configuration registers behind the APB-style port.
// Depends on tfma_pkg for reset values, register indexes and tfma_cfg_type.
module tfma_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [4:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output tfma_pkg::tfma_cfg_type cfg
);
   import tfma_pkg::*;

   logic [2:0]        idx;
   logic              wr_en;
   logic signed [16:0] quad_ff, quad_in;
   logic signed [15:0] lin_ff, lin_in;
   logic [15:0]       offset_ff, offset_in;
   logic [15:0]       fever_ff, fever_in;
   logic [15:0]       high_ff, high_in;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   // write decode
   always_comb begin
      quad_in   = quad_ff;
      lin_in    = lin_ff;
      offset_in = offset_ff;
      fever_in  = fever_ff;
      high_in   = high_ff;
      if (wr_en) begin
         case (idx)
            REG_QUAD:       quad_in   = $signed(csr_pwdata[16:0]);
            REG_LIN:        lin_in    = $signed(csr_pwdata[15:0]);
            REG_OFFSET:     offset_in = csr_pwdata[15:0];
            REG_FEVER:      fever_in  = csr_pwdata[15:0];
            REG_HIGH_FEVER: high_in   = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quad_ff   <= QUAD_RST;
         lin_ff    <= LIN_RST;
         offset_ff <= OFFSET_RST;
         fever_ff  <= FEVER_RST;
         high_ff   <= HIGH_FEVER_RST;
      end else begin
         quad_ff   <= quad_in;
         lin_ff    <= lin_in;
         offset_ff <= offset_in;
         fever_ff  <= fever_in;
         high_ff   <= high_in;
      end
   end

   // read mux, signed registers sign extended
   always_comb begin
      case (idx)
         REG_QUAD:       csr_prdata = {{15{quad_ff[16]}}, quad_ff};
         REG_LIN:        csr_prdata = {{16{lin_ff[15]}}, lin_ff};
         REG_OFFSET:     csr_prdata = {16'd0, offset_ff};
         REG_FEVER:      csr_prdata = {16'd0, fever_ff};
         REG_HIGH_FEVER: csr_prdata = {16'd0, high_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   assign cfg.quad_coef        = quad_ff;
   assign cfg.lin_coef         = lin_ff;
   assign cfg.offset_temp      = offset_ff;
   assign cfg.fever_level      = fever_ff;
   assign cfg.high_fever_level = high_ff;

endmodule

// File: design/tfma_ctrl.sv
// tfma_ctrl: sequencer that walks one sample through the datapath stages
// and owns the result valid flag. Depends on tfma_pkg for tfma_cmd_type.
module tfma_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tfma_pkg::tfma_cmd_type cmd
);
   import tfma_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL1 = 3'd1;
   localparam logic [2:0] S_MUL2 = 3'd2;
   localparam logic [2:0] S_ACC  = 3'd3;
   localparam logic [2:0] S_UPD  = 3'd4;
   localparam logic [2:0] S_DIVA = 3'd5;
   localparam logic [2:0] S_DIVB = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // output register can take a new result
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and stage enables
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            cmd.upd  = 1'b1;
            state_in = S_DIVA;
         end
         S_DIVA: begin
            cmd.diva = 1'b1;
            state_in = S_DIVB;
         end
         S_DIVB: begin
            cmd.divb = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result valid: set on load, cleared when taken
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: design/tfma_dp.sv
// tfma_dp: calibration multipliers, window ring with running sum,
// reciprocal divide for the mean and the threshold compare.
// Depends on tfma_pkg for widths, codes and the cmd/cfg bundle types.
module tfma_dp #(
   parameter int WINDOW_LEN = tfma_pkg::WINDOW_LEN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tfma_pkg::tfma_cmd_type        cmd,
   input  tfma_pkg::tfma_cfg_type        cfg,
   input  logic signed [tfma_pkg::ADC_W-1:0]  adc_code,
   output logic signed [tfma_pkg::TEMP_W-1:0] avg_temp,
   output logic [1:0]                    body_state
);
   import tfma_pkg::*;

   // ring and sum sizing
   localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int SUM_W  = TEMP_W + SLOT_W;
   localparam int LVL_W  = LVL_IN_W + SLOT_W;
   // mean = floor((2*sum + n) / 2n), done as a biased reciprocal multiply
   localparam int DIV_D  = 2 * WINDOW_LEN;
   localparam int RL     = $clog2(DIV_D);
   localparam int U_W    = TEMP_W + RL;
   localparam int RSH    = U_W + RL;
   localparam int M_W    = U_W + 1;
   localparam int PROD_W = U_W + M_W;
   localparam longint unsigned RM_L = ((64'd1 << RSH) + DIV_D - 1) / DIV_D;
   localparam logic [M_W-1:0] RM = M_W'(RM_L);
   localparam logic [U_W-1:0] U_BIAS =
      U_W'(WINDOW_LEN) + U_W'(longint'(WINDOW_LEN) << TEMP_W);
   // calibration polynomial
   localparam int P_W = 54;
   localparam int PHI_W = P_W - 32;
   localparam logic [P_W-1:0] P_HALF = {{(P_W-32){1'b0}}, 1'b1, 31'd0};
   localparam logic signed [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
   localparam logic signed [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

   logic signed [ADC_W-1:0]  c_ff;
   logic signed [31:0]       csq;
   logic [30:0]              c2_ff, c2_in;
   logic signed [31:0]       lc_ff, lc_in;
   logic [LVL_W-1:0]         fev_lvl_ff, fev_lvl_in, hi_lvl_ff, hi_lvl_in;
   logic signed [TEMP_W-1:0] rd_ff;
   logic                     rd_vld_ff;
   logic signed [47:0]       qc2_ff, qc2_in;
   logic [P_W-1:0]           p_sum;
   logic signed [PHI_W-1:0]  phi_ff, phi_in;
   logic signed [TEMP_W-1:0] t_sat, old_val;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [WINDOW_LEN-1:0]    valid_ff;
   logic signed [TEMP_W-1:0] store_mem [WINDOW_LEN];
   logic [U_W-1:0]           u_ff, u_in;
   logic [1:0]               state_ff, state_in;
   logic                     hi_hit, fev_hit;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [TEMP_W-1:0]        qv;
   logic signed [TEMP_W-1:0] avg_ff, avg_in;
   logic [1:0]               body_ff;

   // first multiply step: square, linear term, scaled thresholds
   assign csq        = c_ff * c_ff;
   assign c2_in      = csq[30:0];
   assign lc_in      = $signed(cfg.lin_coef) * c_ff;
   assign fev_lvl_in = LVL_W'(cfg.fever_level) * LVL_W'(WINDOW_LEN);
   assign hi_lvl_in  = LVL_W'(cfg.high_fever_level) * LVL_W'(WINDOW_LEN);

   // second multiply step: quadratic term
   assign qc2_in = $signed(cfg.quad_coef) * $signed({1'b0, c2_ff});

   // polynomial sum with rounding half, keep integer part
   assign p_sum  = P_W'(qc2_ff) + (P_W'(lc_ff) << 20)
                 + (P_W'(cfg.offset_temp) << 32) + P_HALF;
   assign phi_in = $signed(p_sum[P_W-1:32]);

   // clamp sample to the 19 bit range
   always_comb begin
      if (phi_ff[PHI_W-1:TEMP_W-1] == '0 || phi_ff[PHI_W-1:TEMP_W-1] == '1) begin
         t_sat = phi_ff[TEMP_W-1:0];
      end else if (phi_ff[PHI_W-1]) begin
         t_sat = TEMP_MIN;
      end else begin
         t_sat = TEMP_MAX;
      end
   end

   // ring update: slot entries never written read as zero
   assign old_val = rd_vld_ff ? rd_ff : '0;
   assign sum_in  = sum_ff + SUM_W'(t_sat) - SUM_W'(old_val);
   assign slot_in = (slot_ff == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_ff + 1'b1;

   // bias mean numerator to nonnegative, classify on the exact sum
   assign u_in    = U_W'({sum_ff, 1'b0}) + U_BIAS;
   assign hi_hit  = !sum_ff[SUM_W-1] && (sum_ff[SUM_W-2:0] >= (SUM_W-1)'(hi_lvl_ff));
   assign fev_hit = !sum_ff[SUM_W-1] && (sum_ff[SUM_W-2:0] >= (SUM_W-1)'(fev_lvl_ff));
   always_comb begin
      if (hi_hit) begin
         state_in = BODY_HIGH_FEVER;
      end else if (fev_hit) begin
         state_in = BODY_FEVER;
      end else begin
         state_in = BODY_NORMAL;
      end
   end

   // reciprocal multiply, exact floor for every biased numerator
   assign prod_in = PROD_W'(u_ff) * PROD_W'(RM);

   // quotient is mean + 2^18, flipping the top bit removes the bias;
   // the mean of clamped samples always fits, so no clamp is needed here
   assign qv     = prod_ff[RSH +: TEMP_W];
   assign avg_in = $signed({~qv[TEMP_W-1], qv[TEMP_W-2:0]});

   // datapath payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) c_ff <= adc_code;
      if (cmd.mul1) begin
         c2_ff      <= c2_in;
         lc_ff      <= lc_in;
         fev_lvl_ff <= fev_lvl_in;
         hi_lvl_ff  <= hi_lvl_in;
      end
      if (cmd.mul2) qc2_ff <= qc2_in;
      if (cmd.acc)  phi_ff <= phi_in;
      if (cmd.diva) begin
         u_ff     <= u_in;
         state_ff <= state_in;
      end
      if (cmd.divb) prod_ff <= prod_in;
      if (cmd.load_out) begin
         avg_ff  <= avg_in;
         body_ff <= state_ff;
      end
   end

   // window memory: registered read of the slot about to be replaced
   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         rd_ff     <= store_mem[slot_ff];
         rd_vld_ff <= valid_ff[slot_ff];
      end
      if (cmd.upd) store_mem[slot_ff] <= t_sat;
   end

   // ring state: valid bits, write slot and running sum
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         slot_ff  <= '0;
         sum_ff   <= '0;
      end else if (cmd.upd) begin
         valid_ff[slot_ff] <= 1'b1;
         slot_ff           <= slot_in;
         sum_ff            <= sum_in;
      end
   end

   assign avg_temp   = avg_ff;
   assign body_state = body_ff;

endmodule

// File: design/temp_fit_moving_average_classify.sv
// temp_fit_moving_average_classify: top level joining the register port,
// the sequencer and the datapath. Depends on tfma_pkg, tfma_csr,
// tfma_ctrl and tfma_dp.
//
//   channel  ports          handshake        payload
//   request  req_*          valid / ready    adc_code
//   response rsp_*          valid / ready    avg_temp, body_state
//   config   csr_*          APB-style write  quad, lin, offset, two levels
//
// Each sample walks the sequencer states in order: two multiply steps, the
// polynomial sum, the ring update, the mean numerator bias and a reciprocal
// multiply for the mean, then the output load; a new sample is taken in idle.
// Synchronous reset clears the ring valid bits, slot and sum at once; no
// clearing pass. A stalled response holds its register; one more sample
// is accepted and waits in the last step until the register frees.
module temp_fit_moving_average_classify #(
   parameter int WINDOW_LEN = tfma_pkg::WINDOW_LEN_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [tfma_pkg::ADC_W-1:0]   req_adc_code,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tfma_pkg::TEMP_W-1:0]  rsp_avg_temp,
   output logic [1:0]                          rsp_body_state,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [4:0]                          csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import tfma_pkg::*;

   tfma_cfg_type cfg;
   tfma_cmd_type cmd;

   // configuration registers
   tfma_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // stage sequencer
   tfma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // arithmetic and window
   tfma_dp #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg),
      .adc_code   (req_adc_code),
      .avg_temp   (rsp_avg_temp),
      .body_state (rsp_body_state)
   );

endmodule

// File: design/tfma_check.sv
// tfma_check: port-level assertions for the top level, attached by bind.
// Depends only on the top level's port names.
module tfma_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [18:0] rsp_avg_temp,
   input logic [1:0]  rsp_body_state
);

   // after reset the block is empty and ready for a transaction
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("not idle after reset");

   // one sample in flight: ready drops right after acceptance
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after acceptance");

   // no result can appear the cycle after a sample is taken
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_avg_temp) && $stable(rsp_body_state)))
      else $error("stalled result changed");

endmodule

bind temp_fit_moving_average_classify tfma_check u_tfma_check (.*);

// File: verif/temp_fit_moving_average_classify_test.sv
// temp_fit_moving_average_classify_test: self-checking bench for the calibrated
// temperature moving-average classifier; depends on tfma_pkg and the top level.
// Drives random and directed converter codes, predicts every averaged reading.
module temp_fit_moving_average_classify_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tfma_pkg::*;

   localparam int  WIN         = WINDOW_LEN_DEF;
   localparam int  SETTLE      = 24;
   localparam int  CYCLE_LIMIT = 400000;
   localparam int  BURST_ITEMS = 155;
   localparam longint TEMP_HI  = 262143;
   localparam longint TEMP_LO  = -262144;

   typedef struct packed {
      logic signed [TEMP_W-1:0] avg_temp;
      logic [1:0]               body_state;
   } reading_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [ADC_W-1:0]   req_adc_code = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [TEMP_W-1:0]  rsp_avg_temp;
   logic [1:0]                rsp_body_state;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [4:0]                csr_paddr = '0;
   logic [31:0]               csr_pwdata = '0;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   // sample codes waiting to go out, readings the block still owes
   logic signed [ADC_W-1:0]   pending_codes[$];
   reading_type               due_readings[$];

   // shadow of the calibration and level registers
   longint cfg_quad   = QUAD_RST;
   longint cfg_lin    = LIN_RST;
   longint cfg_offset = OFFSET_RST;
   longint cfg_fever  = FEVER_RST;
   longint cfg_high   = HIGH_FEVER_RST;

   // shadow of the averaging ring
   longint win_ring[WIN];
   int     win_slot  = 0;
   longint win_total = 0;

   int     send_gap_pct = 37;
   int     hold_pct     = 84;
   int     fault_count  = 0;
   int     cycle_count  = 0;

   temp_fit_moving_average_classify u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_adc_code   (req_adc_code),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_avg_temp   (rsp_avg_temp),
      .rsp_body_state (rsp_body_state),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic longint clamp_temp(longint v);
      if (v > TEMP_HI) begin
         return TEMP_HI;
      end
      if (v < TEMP_LO) begin
         return TEMP_LO;
      end
      return v;
   endfunction

   // quadratic calibration in 2^-32 steps, rounded half up, then saturated
   function automatic longint sample_temp(longint q, longint l, longint o,
                                          logic signed [ADC_W-1:0] code);
      longint c;
      longint p;
      c = code;
      p = q * c * c + l * c * 64'sd1048576 + o * (64'sd1 <<< 32);
      return clamp_temp((p + 64'sd2147483648) >>> 32);
   endfunction

   function automatic logic [15:0] level_near(longint t);
      if (t < 0) begin
         return 16'd0;
      end
      if (t > 65535) begin
         return 16'hFFFF;
      end
      return 16'(t);
   endfunction

   // push one sample through the shadow ring and queue the owed reading
   function automatic void fold_sample(logic signed [ADC_W-1:0] code);
      longint      t;
      longint      num;
      longint      mean;
      reading_type r;
      t = sample_temp(cfg_quad, cfg_lin, cfg_offset, code);
      win_total = win_total + t - win_ring[win_slot];
      win_ring[win_slot] = t;
      win_slot = (win_slot + 1) % WIN;
      num = 2 * win_total + WIN;
      if (num >= 0) begin
         mean = num / (2 * WIN);
      end else begin
         mean = -((-num + 2 * WIN - 1) / (2 * WIN));
      end
      r.avg_temp = TEMP_W'(clamp_temp(mean));
      if (win_total >= cfg_high * WIN) begin
         r.body_state = BODY_HIGH_FEVER;
      end else if (win_total >= cfg_fever * WIN) begin
         r.body_state = BODY_FEVER;
      end else begin
         r.body_state = BODY_NORMAL;
      end
      due_readings.push_back(r);
   endfunction

   // sample driver: a new transaction only once the previous one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            fold_sample(req_adc_code);
         end
         if (!req_valid || req_ready) begin
            if (pending_codes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               req_valid    <= 1'b1;
               req_adc_code <= pending_codes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // reading monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_readings.size() == 0) begin
               $display("%0t unexpected transaction: avg_temp %0d body_state %0d",
                        $time, rsp_avg_temp, rsp_body_state);
               fault_count = fault_count + 1;
            end else begin
               reading_type r;
               r = due_readings.pop_front();
               if (rsp_avg_temp !== r.avg_temp) begin
                  $display("%0t avg_temp mismatch: expected %0d actual %0d",
                           $time, r.avg_temp, rsp_avg_temp);
                  fault_count = fault_count + 1;
               end
               if (rsp_body_state !== r.body_state) begin
                  $display("%0t body_state mismatch: expected %0d actual %0d",
                           $time, r.body_state, rsp_body_state);
                  fault_count = fault_count + 1;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= hold_pct);
      end
   end

   // register write: setup cycle, access cycle, update the shadow copy
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_QUAD:       cfg_quad   = longint'($signed(value[16:0]));
         REG_LIN:        cfg_lin    = longint'($signed(value[15:0]));
         REG_OFFSET:     cfg_offset = longint'(value[15:0]);
         REG_FEVER:      cfg_fever  = longint'(value[15:0]);
         REG_HIGH_FEVER: cfg_high   = longint'(value[15:0]);
         default: ;
      endcase
   endtask

   // block idle: all codes sent, all readings back, pipeline drained
   task automatic wait_quiet();
      while (pending_codes.size() != 0 || req_valid || due_readings.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   // mostly codes wandering around a center, some full-range noise
   task automatic queue_burst(input int count, input int base);
      int center;
      int v;
      int pick;
      int run;
      center = base;
      run = 0;
      for (int i = 0; i < count; i++) begin
         if (run == 0) begin
            center = base + $urandom_range(1200) - 600;
            run = $urandom_range(40, 20);
         end
         run--;
         pick = $urandom_range(99);
         if (pick < 15) begin
            v = $signed(16'($urandom_range(65535)));
         end else if (pick < 20) begin
            case ($urandom_range(3))
               0: v = -32768;
               1: v = 32767;
               2: v = 0;
               default: v = -1;
            endcase
         end else begin
            v = center + $urandom_range(1024) - 512;
         end
         if (v > 32767) begin
            v = 32767;
         end
         if (v < -32768) begin
            v = -32768;
         end
         pending_codes.push_back(ADC_W'(v));
      end
   endtask

   initial begin
      longint q;
      longint l;
      longint o;
      longint t;
      int     base;
      logic [15:0] fev;
      logic [15:0] hfev;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset calibration: field extremes, then codes around the fever band
      pending_codes.push_back(16'sd0);
      pending_codes.push_back(16'sd32767);
      pending_codes.push_back(-16'sd32768);
      pending_codes.push_back(16'sd1);
      pending_codes.push_back(-16'sd1);
      pending_codes.push_back(16'sh5555);
      pending_codes.push_back(16'shAAAA);
      pending_codes.push_back(16'sh7FF0);
      for (int i = 0; i < 10; i++) begin
         pending_codes.push_back((i % 2 == 0) ? 16'sd14300 : 16'sd14700);
      end
      wait_quiet();

      // sample saturates high
      csr_write(REG_QUAD, 32'(65535));
      csr_write(REG_LIN, 32'(32767));
      csr_write(REG_OFFSET, 32'(65535));
      repeat (3) pending_codes.push_back(16'sd32767);
      wait_quiet();

      // sample saturates low
      csr_write(REG_QUAD, 32'(-65536));
      csr_write(REG_LIN, 32'(-32768));
      csr_write(REG_OFFSET, 32'(0));
      repeat (3) pending_codes.push_back(16'sd32767);
      wait_quiet();

      // random phases; calibration and idle pattern vary between phases
      for (int ph = 0; ph < 6; ph++) begin
         if (ph < 2) begin
            send_gap_pct = 37;
            hold_pct     = 84;
         end else if (ph < 4) begin
            send_gap_pct = 84;
            hold_pct     = 37;
         end else begin
            send_gap_pct = 0;
            hold_pct     = 0;
         end
         case (ph)
            0: begin
               q = -65536;
               l = -32768;
               o = 0;
               base = -$urandom_range(3000, 500);
            end
            1: begin
               q = 65535;
               l = 32767;
               o = 65535;
               base = $urandom_range(2000);
            end
            2, 5: begin
               q = QUAD_RST;
               l = LIN_RST;
               o = OFFSET_RST;
               base = 14400 + $urandom_range(200) - 100;
            end
            default: begin
               q = longint'($urandom_range(131071)) - 65536;
               l = longint'($urandom_range(65535)) - 32768;
               o = $urandom_range(65535);
               base = $signed(16'($urandom_range(65535)));
            end
         endcase
         t = sample_temp(q, l, o, ADC_W'(base));
         fev  = level_near(t - $urandom_range(300));
         hfev = level_near(t + $urandom_range(400) - 200);
         case (ph)
            1: begin
               fev  = 16'd0;
               hfev = 16'hFFFF;
            end
            // high fever threshold below the fever threshold
            3: begin
               hfev = level_near(t - $urandom_range(600, 300));
            end
            // both thresholds equal
            5: begin
               hfev = fev;
            end
            default: ;
         endcase
         csr_write(REG_QUAD, 32'(q));
         csr_write(REG_LIN, 32'(l));
         csr_write(REG_OFFSET, 32'(o));
         csr_write(REG_FEVER, {16'd0, fev});
         csr_write(REG_HIGH_FEVER, {16'd0, hfev});
         queue_burst(BURST_ITEMS, base);
         wait_quiet();
      end

      if (fault_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

endmodule

// File: filelist.f
design/tfma_pkg.sv
design/tfma_csr.sv
design/tfma_ctrl.sv
design/tfma_dp.sv
design/temp_fit_moving_average_classify.sv
design/tfma_check.sv
verif/temp_fit_moving_average_classify_test.sv
